/* src/akc_pkg.sv */
// shared widths, codes and reset values of the alarm keypad controller
package akc_pkg;

  localparam int IN_USER_W  = 3;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam int PW_W      = 14;
  localparam int DELAY_W   = 8;
  localparam int CODE_W    = 7;
  localparam int DIGIT_W   = 4;
  localparam int DCNT_O_W  = 3;
  localparam int PKT_W     = 2;
  localparam int STAT_W    = 2;

  typedef enum logic [IN_USER_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_SENSOR = 3'd1,
    REQ_DIGIT  = 3'd2,
    REQ_ARM    = 3'd3,
    REQ_CANCEL = 3'd4
  } req_t;

  typedef enum logic [PKT_W-1:0] {
    PKT_NONE  = 2'd0,
    PKT_START = 2'd1,
    PKT_STOP  = 2'd2
  } pkt_t;

  typedef enum logic [STAT_W-1:0] {
    ST_NONE    = 2'd0,
    ST_PARTIAL = 2'd1,
    ST_ACCEPT  = 2'd2,
    ST_REJECT  = 2'd3
  } pin_stat_t;

  typedef enum logic [2:0] {
    REG_PASSWORD    = 3'd0,
    REG_EXIT_DELAY  = 3'd1,
    REG_ENTRY_DELAY = 3'd2,
    REG_TRIG_A      = 3'd3,
    REG_TRIG_B      = 3'd4
  } reg_idx_t;

  localparam logic [PW_W-1:0]    PASSWORD_RST = 14'd1234;
  localparam logic [DELAY_W-1:0] DELAY_RST    = 8'd30;
  localparam logic [CODE_W-1:0]  TRIG_A_RST   = 7'b1111110;
  localparam logic [CODE_W-1:0]  TRIG_B_RST   = 7'b1111101;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;

endpackage

/* src/alarm_keypad_controller.sv */
// alarm keypad controller: event decoder, countdowns, pin entry and register port
//
// One request (tick, sensor code, key digit, arm or cancel) is taken per clock
// cycle and produces exactly one registered result. All flag, countdown and pin
// state is updated by a single pass of logic at the accepting edge, so the rate
// is one request per cycle as long as the result side takes its data; in_tready
// drops only while a result waits and out_tready is low. Registers (password,
// exit_delay, entry_delay, trigger_code_a, trigger_code_b) sit at byte addresses
// 0, 4, 8, 12, 16; the user must write them only while the block is idle, which
// the block does not enforce. PIN_DIGITS sets how many digits form one pin entry.
module alarm_keypad_controller #(
  parameter int PIN_DIGITS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [2:0] req_type
  input  logic [akc_pkg::IN_USER_W-1:0] in_tuser,
  // [6:0] sensor_code, [10:7] key_digit, [15:11] zero
  input  logic [akc_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] armed, [1] exit_pending, [2] entry_pending, [3] alarm_on, [4] buzzer_on,
  // [6:5] packet_out, [8:7] pin_status, [22:9] pin_value, [25:23] digits_entered,
  // [33:26] exit_left, [41:34] entry_left, [42] entry_started, [47:43] zero
  output logic [akc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [akc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [akc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [akc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import akc_pkg::*;

  localparam int ACC_W = $clog2(10 ** PIN_DIGITS);
  localparam int CNT_W = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;
  localparam int CMP_W = (ACC_W > PW_W) ? ACC_W : PW_W;

  logic [PW_W-1:0]    password_r;
  logic [DELAY_W-1:0] exit_delay_r;
  logic [DELAY_W-1:0] entry_delay_r;
  logic [CODE_W-1:0]  trig_a_r;
  logic [CODE_W-1:0]  trig_b_r;

  logic               armed_r, armed_nxt;
  logic               exit_flag_r, exit_flag_nxt;
  logic               entry_flag_r, entry_flag_nxt;
  logic               alarm_r, alarm_nxt;
  logic               buzzer_r, buzzer_nxt;
  logic [DELAY_W-1:0] exit_count_r, exit_count_nxt;
  logic [DELAY_W-1:0] entry_count_r, entry_count_nxt;
  logic [CNT_W-1:0]   digit_count_r, digit_count_nxt;
  logic [ACC_W-1:0]   pin_accum_r, pin_accum_nxt;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                  in_fire;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;
  req_t                  req;
  logic [CODE_W-1:0]     code;
  logic [DIGIT_W-1:0]    digit;
  logic [ACC_W+3:0]      acc_ext;
  logic [ACC_W-1:0]      acc_new;
  logic [CNT_W:0]        cnt_inc;
  logic                  pin_done;
  logic                  pin_match;
  logic                  code_hit;
  pkt_t                  packet;
  pin_stat_t             status;
  logic [PW_W-1:0]       shown;
  logic                  started;
  logic [DELAY_W-1:0]    exit_left;
  logic [DELAY_W-1:0]    entry_left;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  assign req   = req_t'(in_tuser);
  assign code  = in_tdata[CODE_W-1:0];
  assign digit = in_tdata[CODE_W+DIGIT_W-1:CODE_W];

  // accum * 10 + digit as shift and add
  assign acc_ext   = ({4'b0, pin_accum_r} << 3) + ({4'b0, pin_accum_r} << 1)
                   + {{ACC_W{1'b0}}, digit};
  assign acc_new   = acc_ext[ACC_W-1:0];
  assign cnt_inc   = {1'b0, digit_count_r} + {{CNT_W{1'b0}}, 1'b1};
  assign pin_done  = cnt_inc >= (CNT_W+1)'(PIN_DIGITS);
  assign pin_match = CMP_W'(acc_new) == CMP_W'(password_r);
  assign code_hit  = (code == trig_a_r) || (code == trig_b_r);

  always_comb begin
    armed_nxt       = armed_r;
    exit_flag_nxt   = exit_flag_r;
    entry_flag_nxt  = entry_flag_r;
    alarm_nxt       = alarm_r;
    buzzer_nxt      = buzzer_r;
    exit_count_nxt  = exit_count_r;
    entry_count_nxt = entry_count_r;
    digit_count_nxt = digit_count_r;
    pin_accum_nxt   = pin_accum_r;
    packet          = PKT_NONE;
    status          = ST_NONE;
    shown           = PW_W'(pin_accum_r);
    started         = 1'b0;
    unique case (req)
      REQ_TICK: begin
        if (exit_flag_r) begin
          if (exit_count_r <= DELAY_W'(1)) begin
            exit_count_nxt = '0;
            exit_flag_nxt  = 1'b0;
            armed_nxt      = 1'b1;
            packet         = PKT_START;
          end else begin
            exit_count_nxt = exit_count_r - DELAY_W'(1);
          end
        end
        if (entry_flag_r) begin
          if (entry_count_r <= DELAY_W'(1)) begin
            entry_count_nxt = '0;
            entry_flag_nxt  = 1'b0;
            alarm_nxt       = 1'b1;
            buzzer_nxt      = 1'b1;
          end else begin
            entry_count_nxt = entry_count_r - DELAY_W'(1);
          end
        end
      end
      REQ_SENSOR: begin
        if (armed_r && code_hit && !alarm_r && !entry_flag_r) begin
          entry_flag_nxt  = 1'b1;
          entry_count_nxt = entry_delay_r;
          started         = 1'b1;
        end
      end
      REQ_DIGIT: begin
        if (digit <= DIGIT_MAX) begin
          shown = PW_W'(acc_new);
          if (pin_done) begin
            if (pin_match) begin
              packet         = PKT_STOP;
              buzzer_nxt     = 1'b0;
              entry_flag_nxt = 1'b0;
              armed_nxt      = 1'b0;
              alarm_nxt      = 1'b0;
              status         = ST_ACCEPT;
            end else begin
              status = ST_REJECT;
            end
            digit_count_nxt = '0;
            pin_accum_nxt   = '0;
          end else begin
            digit_count_nxt = cnt_inc[CNT_W-1:0];
            pin_accum_nxt   = acc_new;
            status          = ST_PARTIAL;
          end
        end
      end
      REQ_ARM: begin
        exit_flag_nxt  = 1'b1;
        exit_count_nxt = exit_delay_r;
      end
      REQ_CANCEL: begin
        exit_flag_nxt  = 1'b0;
        entry_flag_nxt = 1'b0;
        armed_nxt      = 1'b0;
        alarm_nxt      = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign exit_left  = exit_flag_nxt ? exit_count_nxt : '0;
  assign entry_left = entry_flag_nxt ? entry_count_nxt : '0;
  assign out_tdata_nxt = {5'b0, started, entry_left, exit_left,
                          DCNT_O_W'(digit_count_nxt), shown, status, packet,
                          buzzer_nxt, alarm_nxt, entry_flag_nxt, exit_flag_nxt,
                          armed_nxt};

  always_comb begin
    unique case (cfg_idx)
      REG_PASSWORD:    cfg_prdata = CFG_DATA_W'(password_r);
      REG_EXIT_DELAY:  cfg_prdata = CFG_DATA_W'(exit_delay_r);
      REG_ENTRY_DELAY: cfg_prdata = CFG_DATA_W'(entry_delay_r);
      REG_TRIG_A:      cfg_prdata = CFG_DATA_W'(trig_a_r);
      REG_TRIG_B:      cfg_prdata = CFG_DATA_W'(trig_b_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      password_r    <= PASSWORD_RST;
      exit_delay_r  <= DELAY_RST;
      entry_delay_r <= DELAY_RST;
      trig_a_r      <= TRIG_A_RST;
      trig_b_r      <= TRIG_B_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PASSWORD:    password_r    <= cfg_pwdata[PW_W-1:0];
        REG_EXIT_DELAY:  exit_delay_r  <= cfg_pwdata[DELAY_W-1:0];
        REG_ENTRY_DELAY: entry_delay_r <= cfg_pwdata[DELAY_W-1:0];
        REG_TRIG_A:      trig_a_r      <= cfg_pwdata[CODE_W-1:0];
        REG_TRIG_B:      trig_b_r      <= cfg_pwdata[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r       <= 1'b0;
      exit_flag_r   <= 1'b0;
      entry_flag_r  <= 1'b0;
      alarm_r       <= 1'b0;
      buzzer_r      <= 1'b0;
      exit_count_r  <= '0;
      entry_count_r <= '0;
      digit_count_r <= '0;
      pin_accum_r   <= '0;
      out_tvalid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        armed_r       <= armed_nxt;
        exit_flag_r   <= exit_flag_nxt;
        entry_flag_r  <= entry_flag_nxt;
        alarm_r       <= alarm_nxt;
        buzzer_r      <= buzzer_nxt;
        exit_count_r  <= exit_count_nxt;
        entry_count_r <= entry_count_nxt;
        digit_count_r <= digit_count_nxt;
        pin_accum_r   <= pin_accum_nxt;
        out_tvalid_r  <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_entry_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (entry_flag_r || alarm_r) |-> armed_r)
    else $error("entry countdown or alarm while not armed");

  a_entry_alarm_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(entry_flag_r && alarm_r))
    else $error("entry countdown running while alarm sounds");

  a_digit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W+1)'(digit_count_r) < (CNT_W+1)'(PIN_DIGITS))
    else $error("digit count reached pin length");

  a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid_r)
    else $error("accepted request left no result");
`endif

endmodule
